// File: rtl/drive_control_word_sequencer_macros.svh
// Assertion macros used by the checker file.
`ifndef DRIVE_CONTROL_WORD_SEQUENCER_MACROS_SVH
`define DRIVE_CONTROL_WORD_SEQUENCER_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define DCWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication in the same cycle.
`define DCWS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    `DCWS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Implication checked in the following cycle.
`define DCWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `DCWS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: rtl/dcws_pkg.sv
package dcws_pkg;

    // Control word bits that the sequencer actually drives.
    typedef struct packed {
        logic toggle;
        logic dir;
        logic reset_req;
        logic enable;
        logic no_quick_stop;
        logic no_coast_stop;
        logic on;
    } t_drive_word;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_NONE        = 3'd0;
    localparam t_phase PH_FAULT_CLEAR = 3'd1;
    localparam t_phase PH_FAULT       = 3'd2;
    localparam t_phase PH_INHIBITED   = 3'd3;
    localparam t_phase PH_NOT_READY   = 3'd4;
    localparam t_phase PH_READY_ON    = 3'd5;
    localparam t_phase PH_SWITCHED_ON = 3'd6;
    localparam t_phase PH_OPERATING   = 3'd7;

    // Status bit positions.
    localparam int ST_PUR     = 0;
    localparam int ST_READY   = 1;
    localparam int ST_OPEN    = 2;
    localparam int ST_FAULT   = 3;
    localparam int ST_NOFF2   = 4;
    localparam int ST_NOFF3   = 5;
    localparam int ST_INHIBIT = 6;

    // Core status patterns, ordered {inhibit, op_enabled, ready, powerup_ready}.
    localparam logic [3:0] CORE_IDLE     = 4'b0000;
    localparam logic [3:0] CORE_INHIBIT  = 4'b1000;
    localparam logic [3:0] CORE_PUR      = 4'b0001;
    localparam logic [3:0] CORE_SWITCHED = 4'b0011;
    localparam logic [3:0] CORE_OPERATE  = 4'b0111;

    // Positions of the direction and toggle bits within the high control byte.
    localparam int CH_DIR    = 1;
    localparam int CH_TOGGLE = 7;

endpackage

// File: rtl/dcws_step.sv
module dcws_step (
    input  logic [6:0]              i_status,
    input  logic                    i_ready_to_drive,
    input  dcws_pkg::t_drive_word   i_word,
    input  logic                    i_fault_pending,
    output dcws_pkg::t_drive_word   o_word,
    output logic                    o_fault_pending,
    output dcws_pkg::t_phase        o_phase
);

    logic [3:0] w_core;
    logic       w_offs_ok;

    assign w_core = {i_status[dcws_pkg::ST_INHIBIT], i_status[dcws_pkg::ST_OPEN],
                     i_status[dcws_pkg::ST_READY], i_status[dcws_pkg::ST_PUR]};
    assign w_offs_ok = i_status[dcws_pkg::ST_NOFF2] & i_status[dcws_pkg::ST_NOFF3];

    always_comb begin
        o_word          = i_word;
        o_word.toggle   = ~i_word.toggle;
        o_fault_pending = i_fault_pending;
        o_phase         = dcws_pkg::PH_NONE;

        if (i_fault_pending) begin
            // The step after a fault releases the reset request and clears the direction;
            // the status is not looked at.
            o_word.reset_req = ~i_word.reset_req;
            o_word.dir       = 1'b0;
            o_fault_pending  = 1'b0;
            o_phase          = dcws_pkg::PH_FAULT_CLEAR;
        end else if (i_status[dcws_pkg::ST_FAULT]) begin
            o_word.reset_req     = ~i_word.reset_req;
            o_word.on            = 1'b0;
            o_word.no_coast_stop = 1'b0;
            o_word.no_quick_stop = 1'b0;
            o_word.enable        = 1'b0;
            o_word.dir           = 1'b0;
            o_fault_pending      = 1'b1;
            o_phase              = dcws_pkg::PH_FAULT;
        end else if (w_core == dcws_pkg::CORE_INHIBIT) begin
            o_word.no_coast_stop = 1'b1;
            o_word.no_quick_stop = 1'b1;
            o_word.on            = 1'b0;
            o_word.dir           = 1'b0;
            o_phase              = dcws_pkg::PH_INHIBITED;
        end else if (w_core == dcws_pkg::CORE_IDLE && w_offs_ok) begin
            o_word.no_coast_stop = 1'b1;
            o_word.no_quick_stop = 1'b1;
            o_word.on            = 1'b0;
            o_word.dir           = 1'b0;
            o_phase              = dcws_pkg::PH_NOT_READY;
        end else if (w_core == dcws_pkg::CORE_PUR && w_offs_ok) begin
            o_word.no_coast_stop = 1'b1;
            o_word.no_quick_stop = 1'b1;
            if (i_ready_to_drive) begin
                o_word.on = 1'b1;
            end else begin
                o_word.on  = 1'b0;
                o_word.dir = 1'b0;
            end
            o_phase = dcws_pkg::PH_READY_ON;
        end else if ((w_core == dcws_pkg::CORE_SWITCHED || w_core == dcws_pkg::CORE_OPERATE)
                     && w_offs_ok) begin
            o_word.enable        = 1'b1;
            o_word.on            = 1'b1;
            o_word.no_coast_stop = 1'b1;
            o_word.no_quick_stop = 1'b1;
            o_word.dir           = 1'b1;
            o_phase = (w_core == dcws_pkg::CORE_OPERATE) ? dcws_pkg::PH_OPERATING
                                                         : dcws_pkg::PH_SWITCHED_ON;
        end
    end

endmodule

// File: rtl/drive_control_word_sequencer.sv
// Drive control word sequencer. Each accepted status word is latched in an input register,
// decoded combinationally against the held control word and fault flag, and the packed
// control bytes and phase code are loaded into a result register: a new word can be taken
// every cycle while the output does not stall. The control word state advances once per
// word, in acceptance order; a stall on the output holds the result register and backs up
// into the input register before the input is stalled.
module drive_control_word_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_status_low,
    input  logic       i_ready_to_drive,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_control_low,
    output logic [7:0] o_control_high,
    output logic [2:0] o_phase
);

    logic                  r_in_valid;
    logic [6:0]            r_in_status;
    logic                  r_in_r2d;
    logic                  r_out_valid;
    logic [7:0]            r_out_low;
    logic [7:0]            r_out_high;
    dcws_pkg::t_phase      r_out_phase;
    dcws_pkg::t_drive_word r_word;
    logic                  r_fault_pending;

    dcws_pkg::t_drive_word n_word;
    logic                  n_fault_pending;
    dcws_pkg::t_phase      n_phase;

    logic w_out_free;
    logic w_adv;
    logic w_in_load;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign w_in_load  = !r_in_valid || w_out_free;
    assign o_stall    = !w_in_load;

    dcws_step u_step (
        .i_status         (r_in_status),
        .i_ready_to_drive (r_in_r2d),
        .i_word           (r_word),
        .i_fault_pending  (r_fault_pending),
        .o_word           (n_word),
        .o_fault_pending  (n_fault_pending),
        .o_phase          (n_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_word          <= '0;
            r_fault_pending <= 1'b0;
        end else begin
            if (w_in_load) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_word          <= n_word;
                r_fault_pending <= n_fault_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_valid) begin
            r_in_status <= i_status_low[6:0];
            r_in_r2d    <= i_ready_to_drive;
        end
        if (w_adv) begin
            r_out_low   <= {n_word.reset_req, 3'b000, n_word.enable, n_word.no_quick_stop,
                            n_word.no_coast_stop, n_word.on};
            r_out_high  <= {n_word.toggle, 5'b00000, n_word.dir, 1'b0};
            r_out_phase <= n_phase;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_control_low  = r_out_low;
    assign o_control_high = r_out_high;
    assign o_phase        = r_out_phase;

endmodule

// File: rtl/dcws_checker.sv
`include "drive_control_word_sequencer_macros.svh"

module dcws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_control_low,
    input logic [7:0] o_control_high,
    input logic [2:0] o_phase
);

    logic r_seen;
    logic r_last_toggle;
    logic r_last_fault;
    logic w_out_acc;
    logic w_out_held;
    logic w_toggle_flip;
    logic w_fault_clear;
    logic w_fault_out;
    logic w_drive_off;

    assign w_out_acc     = o_valid && !i_stall;
    assign w_out_held    = o_valid && i_stall;
    assign w_toggle_flip = o_control_high[dcws_pkg::CH_TOGGLE] != r_last_toggle;
    assign w_fault_clear = o_phase == dcws_pkg::PH_FAULT_CLEAR;
    assign w_fault_out   = o_valid && (o_phase == dcws_pkg::PH_FAULT);
    assign w_drive_off   = (o_control_low[3:0] == 4'b0000) && !o_control_high[dcws_pkg::CH_DIR];

    // Remember what the last delivered word showed, to compare with the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= 1'b0;
            r_last_toggle <= 1'b0;
            r_last_fault  <= 1'b0;
        end else if (w_out_acc) begin
            r_seen        <= 1'b1;
            r_last_toggle <= o_control_high[dcws_pkg::CH_TOGGLE];
            r_last_fault  <= (o_phase == dcws_pkg::PH_FAULT);
        end
    end

    `DCWS_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, w_out_held, o_valid, "result dropped in stall")
    `DCWS_ASSERT_IMPLY(a_stall_when_full, i_clk, i_rst_n, o_stall, w_out_held, "needless stall")
    `DCWS_ASSERT_IMPLY(a_toggle_alt, i_clk, i_rst_n, w_out_acc && r_seen, w_toggle_flip, "no toggle")
    `DCWS_ASSERT_IMPLY(a_fault_clear, i_clk, i_rst_n, w_out_acc && r_last_fault, w_fault_clear, "no clear")
    `DCWS_ASSERT_IMPLY(a_fault_drive, i_clk, i_rst_n, w_fault_out, w_drive_off, "drive kept on fault")

endmodule

bind drive_control_word_sequencer dcws_checker u_dcws_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_control_low    (o_control_low),
    .o_control_high   (o_control_high),
    .o_phase          (o_phase)
);

// File: bench/tb.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0]       ctl_low;
    logic [7:0]       ctl_high;
    dcws_pkg::t_phase phase;
} t_control_result;

class control_scoreboard;
    dcws_pkg::t_drive_word word_state;
    logic                  fault_pending;
    t_control_result       expected_words[$];
    int                    errors;

    function new();
        word_state    = '0;
        fault_pending = 1'b0;
        errors        = 0;
    endfunction

    // Advances the shadow control word for one accepted status word and queues the result.
    function void note_word(logic [7:0] status, logic r2d);
        logic [3:0]            core;
        logic                  offs_ok;
        dcws_pkg::t_drive_word w;
        dcws_pkg::t_phase      ph;
        t_control_result       res;

        core    = {status[dcws_pkg::ST_INHIBIT], status[dcws_pkg::ST_OPEN],
                   status[dcws_pkg::ST_READY], status[dcws_pkg::ST_PUR]};
        offs_ok = status[dcws_pkg::ST_NOFF2] & status[dcws_pkg::ST_NOFF3];
        w       = word_state;
        w.toggle = ~w.toggle;

        if (fault_pending) begin
            // The status byte is not looked at while the fault is being cleared.
            w.reset_req   = ~w.reset_req;
            w.dir         = 1'b0;
            fault_pending = 1'b0;
            ph            = dcws_pkg::PH_FAULT_CLEAR;
        end else if (status[dcws_pkg::ST_FAULT]) begin
            w.reset_req     = ~w.reset_req;
            w.on            = 1'b0;
            w.no_coast_stop = 1'b0;
            w.no_quick_stop = 1'b0;
            w.enable        = 1'b0;
            w.dir           = 1'b0;
            fault_pending   = 1'b1;
            ph              = dcws_pkg::PH_FAULT;
        end else if (core == dcws_pkg::CORE_INHIBIT) begin
            w.no_coast_stop = 1'b1;
            w.no_quick_stop = 1'b1;
            w.on            = 1'b0;
            w.dir           = 1'b0;
            ph              = dcws_pkg::PH_INHIBITED;
        end else if (core == dcws_pkg::CORE_IDLE && offs_ok) begin
            w.no_coast_stop = 1'b1;
            w.no_quick_stop = 1'b1;
            w.on            = 1'b0;
            w.dir           = 1'b0;
            ph              = dcws_pkg::PH_NOT_READY;
        end else if (core == dcws_pkg::CORE_PUR && offs_ok) begin
            w.no_coast_stop = 1'b1;
            w.no_quick_stop = 1'b1;
            if (r2d) begin
                w.on = 1'b1;
            end else begin
                w.on  = 1'b0;
                w.dir = 1'b0;
            end
            ph = dcws_pkg::PH_READY_ON;
        end else if ((core == dcws_pkg::CORE_SWITCHED || core == dcws_pkg::CORE_OPERATE)
                     && offs_ok) begin
            w.enable        = 1'b1;
            w.on            = 1'b1;
            w.no_coast_stop = 1'b1;
            w.no_quick_stop = 1'b1;
            w.dir           = 1'b1;
            ph              = (core == dcws_pkg::CORE_SWITCHED) ? dcws_pkg::PH_SWITCHED_ON
                                                                : dcws_pkg::PH_OPERATING;
        end else begin
            ph = dcws_pkg::PH_NONE;
        end

        word_state   = w;
        res.ctl_low  = {w.reset_req, 3'b000, w.enable, w.no_quick_stop, w.no_coast_stop, w.on};
        res.ctl_high = 8'h00;
        res.ctl_high[dcws_pkg::CH_DIR]    = w.dir;
        res.ctl_high[dcws_pkg::CH_TOGGLE] = w.toggle;
        res.phase    = ph;
        expected_words.push_back(res);
    endfunction

    function void check_result(logic [7:0] ctl_low, logic [7:0] ctl_high,
                               dcws_pkg::t_phase phase);
        t_control_result exp_res;

        if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word low=%h high=%h phase=%0d",
                     $time, ctl_low, ctl_high, phase);
            errors++;
        end else begin
            exp_res = expected_words.pop_front();
            if (ctl_low !== exp_res.ctl_low) begin
                $display("%0t: control_low expected %h actual %h",
                         $time, exp_res.ctl_low, ctl_low);
                errors++;
            end
            if (ctl_high !== exp_res.ctl_high) begin
                $display("%0t: control_high expected %h actual %h",
                         $time, exp_res.ctl_high, ctl_high);
                errors++;
            end
            if (phase !== exp_res.phase) begin
                $display("%0t: phase expected %0d actual %0d",
                         $time, exp_res.phase, phase);
                errors++;
            end
        end
    endfunction

    function int waiting();
        return expected_words.size();
    endfunction
endclass

module tb;

    localparam int RANDOM_WORDS   = 800;
    localparam int QUIET_LIMIT    = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int TAIL_CYCLES    = 10;

    localparam logic [7:0] M_PUR     = 8'(1 << dcws_pkg::ST_PUR);
    localparam logic [7:0] M_READY   = 8'(1 << dcws_pkg::ST_READY);
    localparam logic [7:0] M_OPEN    = 8'(1 << dcws_pkg::ST_OPEN);
    localparam logic [7:0] M_FAULT   = 8'(1 << dcws_pkg::ST_FAULT);
    localparam logic [7:0] M_NOFF2   = 8'(1 << dcws_pkg::ST_NOFF2);
    localparam logic [7:0] M_NOFF3   = 8'(1 << dcws_pkg::ST_NOFF3);
    localparam logic [7:0] M_INHIBIT = 8'(1 << dcws_pkg::ST_INHIBIT);
    localparam logic [7:0] M_SPARE   = 8'h80;
    localparam logic [7:0] M_NOFF    = M_NOFF2 | M_NOFF3;
    localparam logic [7:0] S_RDY_ON  = M_NOFF | M_PUR;
    localparam logic [7:0] S_SW_ON   = M_NOFF | M_PUR | M_READY;
    localparam logic [7:0] S_OPER    = M_NOFF | M_PUR | M_READY | M_OPEN;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_status_low;
    logic       i_ready_to_drive;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_control_low;
    logic [7:0] o_control_high;
    logic [2:0] o_phase;

    control_scoreboard sb = new();

    int tx_idle_pct = 20;
    int rx_idle_pct = 20;
    bit hold_req    = 1'b0;
    int quiet_cycles = 0;

    drive_control_word_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_status_low     (i_status_low),
        .i_ready_to_drive (i_ready_to_drive),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_control_low    (o_control_low),
        .o_control_high   (o_control_high),
        .o_phase          (o_phase)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: random stalls, or one long hold-off when the sender asks for it.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_control_low, o_control_high, o_phase);
            end
            if (i_valid && !o_stall) begin
                sb.note_word(i_status_low, i_ready_to_drive);
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task send_word(input logic [7:0] status, input logic r2d);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_status_low     <= status;
        i_ready_to_drive <= r2d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.waiting() != 0);
    endtask

    initial begin
        int         stage;
        int         k;
        logic [7:0] st;
        logic       r2d;

        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_status_low     <= 8'h00;
        i_ready_to_drive <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through every phase, the fault handshake and the ignored bits.
        send_word(8'h00, 1'b0);
        send_word(M_NOFF, 1'b0);
        send_word(S_RDY_ON, 1'b0);
        send_word(S_RDY_ON, 1'b1);
        send_word(S_SW_ON, 1'b0);
        send_word(S_OPER, 1'b1);
        send_word(S_OPER | M_SPARE, 1'b1);
        send_word(M_FAULT, 1'b0);
        send_word(S_OPER, 1'b1);
        send_word(S_OPER, 1'b1);
        send_word(M_INHIBIT, 1'b0);
        send_word(M_INHIBIT | M_NOFF, 1'b1);
        send_word(M_INHIBIT | M_SPARE, 1'b0);
        send_word(S_RDY_ON, 1'b1);
        send_word(S_SW_ON, 1'b1);
        send_word(S_RDY_ON, 1'b0);
        send_word(S_SW_ON, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(M_NOFF3, 1'b1);
        send_word(M_NOFF | M_PUR | M_OPEN, 1'b1);
        send_word(M_INHIBIT | S_OPER, 1'b1);
        send_word(M_NOFF2 | M_PUR | M_READY, 1'b1);
        drain_results();

        // Mostly power-up sequences with faults and inhibits mixed in, plus raw noise.
        stage = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 150) begin
                hold_req    = 1'b1;
                tx_idle_pct = 0;
            end else if (n == 250) begin
                tx_idle_pct = 20;
            end else if (n == 400) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (n == 600) begin
                tx_idle_pct = 20;
                rx_idle_pct = 20;
            end else if (n == 650) begin
                drain_results();
            end

            k = $urandom_range(99);
            if (k < 20) begin
                st = 8'($urandom_range(255));
            end else if (k < 26) begin
                st    = 8'($urandom_range(255)) | M_FAULT;
                stage = 0;
            end else if (k < 32) begin
                st    = M_INHIBIT | (8'($urandom_range(3)) << dcws_pkg::ST_NOFF2);
                stage = 0;
            end else begin
                case (stage)
                    0:       st = M_NOFF;
                    1:       st = S_RDY_ON;
                    2:       st = S_SW_ON;
                    default: st = S_OPER;
                endcase
                if (stage < 3 && $urandom_range(99) < 60) begin
                    stage++;
                end
            end
            st[7] = 1'($urandom_range(1));
            r2d   = ($urandom_range(99) < 70);
            send_word(st, r2d);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
